>>> sv/keyed_count_slot_table_core_assert.svh
// Assertion macros shared by the slot table RTL.
`ifndef KEYED_COUNT_SLOT_TABLE_CORE_ASSERT_SVH
`define KEYED_COUNT_SLOT_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define KCST_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define KCST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/kcst_pkg.sv
// Shared sizes and port bundles of the keyed count slot table.
package kcst_pkg;

   localparam int SLOTS  = 32;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SCAN_W = $clog2(SLOTS + 1);
   localparam int KEY_W  = 16;
   localparam int CNT_W  = 32;
   localparam int AMT_W  = 16;
   localparam int IDX_W  = 5;

   // Request codes carried on the opcode field.
   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_SWAP = 1'b1;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
      logic [KEY_W-1:0]  key;
      logic [CNT_W-1:0]  count;
   } st_wr_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
   } st_rd_type;

endpackage

>>> sv/kcst_store.sv
// Slot store: key and count memories with per-slot valid bits and a registered read.
module kcst_store import kcst_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  st_wr_type        wr,
   input  st_rd_type        rd,
   output logic [KEY_W-1:0] rd_key,
   output logic [CNT_W-1:0] rd_count
);

   logic [KEY_W-1:0] key_mem [SLOTS];
   logic [CNT_W-1:0] cnt_mem [SLOTS];
   logic [SLOTS-1:0] valid_ff;
   logic [KEY_W-1:0] raw_key_ff;
   logic [CNT_W-1:0] raw_count_ff;
   logic             raw_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         key_mem[wr.addr] <= wr.key;
         cnt_mem[wr.addr] <= wr.count;
      end
      if (rd.en) begin
         raw_key_ff   <= key_mem[rd.addr];
         raw_count_ff <= cnt_mem[rd.addr];
      end
   end

   // A slot never written since reset reads as empty with a zero count.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         raw_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         if (rd.en) begin
            raw_valid_ff <= valid_ff[rd.addr];
         end
      end
   end

   assign rd_key   = raw_valid_ff ? raw_key_ff   : '0;
   assign rd_count = raw_valid_ff ? raw_count_ff : '0;

endmodule

>>> sv/keyed_count_slot_table_core.sv
// Keyed count slot table: sequencer, saturating adder and result register.
// An add with no matching slot scans every slot of the store before its result strobe
// (one read per cycle over the slot store plus write-back); a match ends the scan early.
// A swap steps through its states in order: read slot a, read slot b, write a, write b.
// One item at a time: busy stays high from acceptance until the cycle of the result strobe.
// Synchronous active-high reset empties every slot at once through the valid bits.
// Each result is shown for exactly one cycle on rsp_valid; the receiver cannot stall it.
`include "keyed_count_slot_table_core_assert.svh"

module keyed_count_slot_table_core import kcst_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_opcode,
   input  logic [KEY_W-1:0]        req_item_key,
   input  logic signed [AMT_W-1:0] req_amount,
   input  logic [IDX_W-1:0]        req_slot_a,
   input  logic [IDX_W-1:0]        req_slot_b,
   output logic                    rsp_valid,
   output logic                    rsp_success,
   output logic [IDX_W-1:0]        rsp_slot_used
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_MERGE  = 3'd2;
   localparam logic [2:0] ST_PLACE  = 3'd3;
   localparam logic [2:0] ST_SW_RDA = 3'd4;
   localparam logic [2:0] ST_SW_RDB = 3'd5;
   localparam logic [2:0] ST_SW_WRA = 3'd6;
   localparam logic [2:0] ST_SW_WRB = 3'd7;

   localparam logic [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};
   localparam logic [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};

   logic [2:0]        state_ff,        state_in;
   logic [KEY_W-1:0]  key_ff,          key_in;
   logic [AMT_W-1:0]  amt_ff,          amt_in;
   logic [SLOT_W-1:0] slot_a_ff,       slot_a_in;
   logic [SLOT_W-1:0] slot_b_ff,       slot_b_in;
   logic [IDX_W-1:0]  tag_ff,          tag_in;
   logic              swap_ok_ff,      swap_ok_in;
   logic [SCAN_W-1:0] iss_ff,          iss_in;
   logic              have_empty_ff,   have_empty_in;
   logic [SLOT_W-1:0] empty_at_ff,     empty_at_in;
   logic [SLOT_W-1:0] hit_idx_ff,      hit_idx_in;
   logic [CNT_W-1:0]  hit_count_ff,    hit_count_in;
   logic [KEY_W-1:0]  tmp_key_ff,      tmp_key_in;
   logic [CNT_W-1:0]  tmp_count_ff,    tmp_count_in;
   logic              rsp_valid_ff,    rsp_valid_in;
   logic              rsp_success_ff,  rsp_success_in;
   logic [IDX_W-1:0]  rsp_slot_ff,     rsp_slot_in;

   st_wr_type         wr;
   st_rd_type         rd;
   logic [KEY_W-1:0]  rd_key;
   logic [CNT_W-1:0]  rd_count;
   logic [SLOT_W-1:0] cmp_idx;
   logic [CNT_W:0]    sum_wide;
   logic [CNT_W-1:0]  sum_sat;
   logic [CNT_W-1:0]  amt_ext;

   kcst_store u_store (
      .clock    (clock),
      .reset    (reset),
      .wr       (wr),
      .rd       (rd),
      .rd_key   (rd_key),
      .rd_count (rd_count)
   );

   // The slot whose read data is on the store output during the scan is the one issued in the
   // previous cycle.
   assign cmp_idx = SLOT_W'(iss_ff - SCAN_W'(1));

   // The saturating adder: a 33-bit add of the matched count and the amount,
   // clamped to the signed 32-bit limits when the two top bits disagree.
   assign amt_ext  = {{(CNT_W-AMT_W){amt_ff[AMT_W-1]}}, amt_ff};
   assign sum_wide = {hit_count_ff[CNT_W-1], hit_count_ff} + {amt_ext[CNT_W-1], amt_ext};
   always_comb begin
      if (sum_wide[CNT_W] != sum_wide[CNT_W-1]) begin
         sum_sat = sum_wide[CNT_W] ? CNT_MIN : CNT_MAX;
      end else begin
         sum_sat = sum_wide[CNT_W-1:0];
      end
   end

   always_comb begin
      state_in       = state_ff;
      key_in         = key_ff;
      amt_in         = amt_ff;
      slot_a_in      = slot_a_ff;
      slot_b_in      = slot_b_ff;
      tag_in         = tag_ff;
      swap_ok_in     = swap_ok_ff;
      iss_in         = iss_ff;
      have_empty_in  = have_empty_ff;
      empty_at_in    = empty_at_ff;
      hit_idx_in     = hit_idx_ff;
      hit_count_in   = hit_count_ff;
      tmp_key_in     = tmp_key_ff;
      tmp_count_in   = tmp_count_ff;
      rsp_valid_in   = 1'b0;
      rsp_success_in = rsp_success_ff;
      rsp_slot_in    = rsp_slot_ff;
      wr             = '0;
      rd             = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               key_in        = req_item_key;
               amt_in        = req_amount;
               slot_a_in     = SLOT_W'(req_slot_a);
               slot_b_in     = SLOT_W'(req_slot_b);
               tag_in        = req_slot_a;
               swap_ok_in    = (32'(req_slot_a) < 32'(SLOTS)) && (32'(req_slot_b) < 32'(SLOTS));
               iss_in        = '0;
               have_empty_in = 1'b0;
               empty_at_in   = '0;
               state_in      = (req_opcode == OP_SWAP) ? ST_SW_RDA : ST_SCAN;
            end
         end

         ST_SCAN: begin
            // Issue the next read while the previous slot's data is checked.
            rd.en   = iss_ff < SCAN_W'(SLOTS);
            rd.addr = iss_ff[SLOT_W-1:0];
            iss_in  = iss_ff + SCAN_W'(1);
            if (iss_ff != '0) begin
               if (rd_key == '0) begin
                  if (!have_empty_ff) begin
                     have_empty_in = 1'b1;
                     empty_at_in   = cmp_idx;
                  end
               end else if (rd_key == key_ff) begin
                  hit_idx_in   = cmp_idx;
                  hit_count_in = rd_count;
                  state_in     = ST_MERGE;
               end
            end
            if (iss_ff == SCAN_W'(SLOTS) && !(rd_key != '0 && rd_key == key_ff)) begin
               state_in = ST_PLACE;
            end
         end

         ST_MERGE: begin
            wr.en          = 1'b1;
            wr.addr        = hit_idx_ff;
            wr.key         = key_ff;
            wr.count       = sum_sat;
            rsp_valid_in   = 1'b1;
            rsp_success_in = 1'b1;
            rsp_slot_in    = IDX_W'(hit_idx_ff);
            state_in       = ST_IDLE;
         end

         ST_PLACE: begin
            // A zero key finds its empty slot but never claims it.
            wr.en          = have_empty_ff && (key_ff != '0);
            wr.addr        = empty_at_ff;
            wr.key         = key_ff;
            wr.count       = amt_ext;
            rsp_valid_in   = 1'b1;
            rsp_success_in = have_empty_ff;
            rsp_slot_in    = have_empty_ff ? IDX_W'(empty_at_ff) : '0;
            state_in       = ST_IDLE;
         end

         ST_SW_RDA: begin
            rd.en    = 1'b1;
            rd.addr  = slot_a_ff;
            state_in = ST_SW_RDB;
         end

         ST_SW_RDB: begin
            rd.en        = 1'b1;
            rd.addr      = slot_b_ff;
            tmp_key_in   = rd_key;
            tmp_count_in = rd_count;
            state_in     = ST_SW_WRA;
         end

         ST_SW_WRA: begin
            wr.en    = swap_ok_ff;
            wr.addr  = slot_a_ff;
            wr.key   = rd_key;
            wr.count = rd_count;
            state_in = ST_SW_WRB;
         end

         ST_SW_WRB: begin
            wr.en          = swap_ok_ff;
            wr.addr        = slot_b_ff;
            wr.key         = tmp_key_ff;
            wr.count       = tmp_count_ff;
            rsp_valid_in   = 1'b1;
            rsp_success_in = 1'b1;
            rsp_slot_in    = tag_ff;
            state_in       = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff         <= key_in;
      amt_ff         <= amt_in;
      slot_a_ff      <= slot_a_in;
      slot_b_ff      <= slot_b_in;
      tag_ff         <= tag_in;
      swap_ok_ff     <= swap_ok_in;
      iss_ff         <= iss_in;
      have_empty_ff  <= have_empty_in;
      empty_at_ff    <= empty_at_in;
      hit_idx_ff     <= hit_idx_in;
      hit_count_ff   <= hit_count_in;
      tmp_key_ff     <= tmp_key_in;
      tmp_count_ff   <= tmp_count_in;
      rsp_success_ff <= rsp_success_in;
      rsp_slot_ff    <= rsp_slot_in;
   end

   assign busy          = state_ff != ST_IDLE;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_success   = rsp_success_ff;
   assign rsp_slot_used = rsp_slot_ff;

   // Every item passes through working states before its result, so strobes never abut.
   `KCST_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid_ff, !rsp_valid_ff, "result strobes in consecutive cycles")
   // An accepted item always takes the sequencer out of idle.
   `KCST_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accepted item left the block idle")
   // A failed add always reports slot zero.
   `KCST_ASSERT_NOW(a_fail_slot_zero, clock, reset, rsp_valid_ff && !rsp_success_ff, rsp_slot_ff == '0, "failed add names a slot")
   // The result appears exactly as the sequencer returns to idle.
   `KCST_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_valid_ff, !busy, "result strobe while still busy")

endmodule
